>>> hw/rtl/lsw_pkg.sv
// Shared types and constants of the LFSR seed word generator.
package lsw_pkg;

  localparam int unsigned LfsrW  = 16;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CntW   = 7;

  localparam logic [LfsrW-1:0] LfsrResetVal = 16'h5a5a;

  // Steps after the leading discard step, minus one, for each word kind.
  localparam logic [CntW-1:0] LastWord32 = 7'd63;
  localparam logic [CntW-1:0] LastWord64 = 7'd127;

  typedef enum logic [1:0] {
    KindBit    = 2'd0,
    KindWord32 = 2'd1,
    KindWord64 = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [LfsrW-1:0] seed;
  } lfsr_ctl_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } col_ctl_t;

endpackage

>>> hw/rtl/lsw_in_if.sv
// Input channel of the LFSR seed word generator: kind and seed.
interface lsw_in_if;
  import lsw_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [LfsrW-1:0] seed;

  modport source (output valid, output kind, output seed, input ready);
  modport sink (input valid, input kind, input seed, output ready);
endinterface

>>> hw/rtl/lsw_out_if.sv
// Output channel of the LFSR seed word generator: the generated value.
interface lsw_out_if;
  import lsw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> hw/rtl/lsw_lfsr.sv
// The 16-bit Fibonacci LFSR with optional seed load ahead of a step.
module lsw_lfsr import lsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfsr_ctl_t        ctl_i,
  output logic             fb_o,
  output logic [LfsrW-1:0] state_o
);

  logic [LfsrW-1:0] lfsr_q, lfsr_d, src;

  // A load replaces the current register contents with the seed ahead of the step.
  assign src  = ctl_i.load ? ctl_i.seed : lfsr_q;
  assign fb_o = src[0] ^ src[2] ^ src[3] ^ src[5];

  always_comb begin
    lfsr_d = lfsr_q;
    if (ctl_i.step) begin
      lfsr_d = {fb_o, src[LfsrW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LfsrResetVal;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

  assign state_o = lfsr_q;

endmodule

>>> hw/rtl/lsw_collect.sv
// Bit-serial collector that packs generated bits, first bit most significant.
module lsw_collect import lsw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  col_ctl_t          ctl_i,
  input  logic              bit_i,
  output logic [ValueW-1:0] value_o
);

  logic [ValueW-1:0] col_q, col_d;

  always_comb begin
    col_d = col_q;
    if (ctl_i.clear) begin
      col_d = {{(ValueW-1){1'b0}}, ctl_i.shift & bit_i};
    end else if (ctl_i.shift) begin
      col_d = {col_q[ValueW-2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign value_o = col_q;

endmodule

>>> hw/rtl/lfsr_seed_word_generator_unit.sv
// A bit item is done in its accepting step; a 32-bit or 64-bit word runs on through
// its run phase, and the result then moves into the output register.
// One LFSR step per cycle sets the pace, and a new item is taken while the last
// result waits.
// Reset: the LFSR returns to 0x5a5a, the sequencer idles and the output is empty.
module lfsr_seed_word_generator_unit import lsw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsw_in_if.sink    in_i,
  lsw_out_if.source out_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e            state_q, start_state;
  logic [CntW-1:0]   cnt_q, last_q, start_last;
  logic              out_valid_q;
  logic [ValueW-1:0] val_q;

  logic              out_free, in_ready, accept, fb, collect_now;
  logic [LfsrW-1:0]  lfsr_state;
  logic [ValueW-1:0] col_value;
  kind_e             kind;
  lfsr_ctl_t         lfsr_ctl;
  col_ctl_t          col_ctl;

  // The output register frees up when it is empty or its transfer completes.
  assign out_free = !out_valid_q || out_o.ready;

  // A new item enters from idle, or in the same cycle that a finished result
  // moves into the output register.
  assign in_ready   = (state_q == StIdle) || ((state_q == StDone) && out_free);
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign kind       = kind_e'(in_i.kind);

  // In the run phase each round is 16 discarded steps and then 16 collected
  // steps, so bit 4 of the step count marks the collecting half.
  assign collect_now = (state_q == StRun) && cnt_q[4];

  // The accepting cycle loads the seed when it is nonzero and takes the first
  // step. A bit item collects that step; word items discard it. An undefined
  // kind neither loads nor steps and yields zero.
  always_comb begin
    lfsr_ctl.seed  = in_i.seed;
    lfsr_ctl.load  = 1'b0;
    lfsr_ctl.step  = 1'b0;
    col_ctl.clear  = 1'b0;
    col_ctl.shift  = 1'b0;
    start_state    = StDone;
    start_last     = LastWord64;
    if (accept) begin
      col_ctl.clear = 1'b1;
      case (kind)
        KindBit: begin
          lfsr_ctl.load = (in_i.seed != '0);
          lfsr_ctl.step = 1'b1;
          col_ctl.shift = 1'b1;
        end
        KindWord32: begin
          lfsr_ctl.load = (in_i.seed != '0);
          lfsr_ctl.step = 1'b1;
          start_state   = StRun;
          start_last    = LastWord32;
        end
        KindWord64: begin
          lfsr_ctl.load = (in_i.seed != '0);
          lfsr_ctl.step = 1'b1;
          start_state   = StRun;
        end
        default: begin
          start_state = StDone;
        end
      endcase
    end else if (state_q == StRun) begin
      lfsr_ctl.step = 1'b1;
      col_ctl.shift = collect_now;
    end
  end

  lsw_lfsr u_lfsr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lfsr_ctl),
    .fb_o    (fb),
    .state_o (lfsr_state)
  );

  lsw_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (col_ctl),
    .bit_i   (fb),
    .value_o (col_value)
  );

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      last_q      <= LastWord64;
      out_valid_q <= 1'b0;
      val_q       <= '0;
    end else begin
      if (accept) begin
        // A new item overrides the transition back to idle.
        state_q <= start_state;
        cnt_q   <= '0;
        last_q  <= start_last;
      end else begin
        case (state_q)
          StIdle: begin
          end
          StRun: begin
            if (cnt_q == last_q) begin
              state_q <= StDone;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          StDone: begin
            if (out_free) begin
              state_q <= StIdle;
            end
          end
          default: begin
            state_q <= StIdle;
          end
        endcase
      end
      // A finished result moves into the output register as soon as it frees up.
      if ((state_q == StDone) && out_free) begin
        val_q       <= col_value;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = val_q;

  // Zero is never loaded and never reached by stepping.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lfsr_state != '0)
    else $error("LFSR holds the all-zero state");

  // A bit item or an undefined kind finishes right after its accepting cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == KindBit || kind == KindNone) |=> state_q == StDone)
    else $error("short item did not finish at once");

  // The step count never runs past the end of the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> cnt_q <= last_q)
    else $error("step count beyond the last step");

  // A result shows up only when a finished item leaves the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result appeared without a finished item");

  // No item is taken while steps are still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> !in_ready)
    else $error("input ready during the run phase");

endmodule
